### hdl/stt_pkg.sv
// Shared types, codes and helpers for the source text tokenizer.
// No dependencies; every module of the tokenizer imports this package.
package stt_pkg;

  // Widths that the result fields fix.
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned LINE_W = 24;
  localparam int unsigned LEN_W  = 7;

  // Event slots per input byte, in emission order:
  // pending escape, close, open, character, symbol end, final escape, final close.
  localparam int unsigned NSLOT   = 7;
  localparam int unsigned SLOT_W  = $clog2(NSLOT);
  localparam int unsigned SLOT_PRE_ESC = 0;
  localparam int unsigned SLOT_CLOSE   = 1;
  localparam int unsigned SLOT_OPEN    = 2;
  localparam int unsigned SLOT_CHAR    = 3;
  localparam int unsigned SLOT_SYM_END = 4;
  localparam int unsigned SLOT_EOT_ESC = 5;
  localparam int unsigned SLOT_EOT_END = 6;

  // Depth of the bundle queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Fixed character codes.
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  // Configuration register indexes.
  localparam logic REG_QUOTE  = 1'b0;
  localparam logic REG_ESCAPE = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CHAR_W-1:0] QUOTE_RESET  = 8'd34;
  localparam logic [CHAR_W-1:0] ESCAPE_RESET = 8'd92;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_NUM  = 4'b0010,
    MODE_WORD = 4'b0100,
    MODE_LIT  = 4'b1000
  } lex_mode_e;

  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_CHAR  = 2'd1,
    EV_END   = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    TK_NUM  = 2'd0,
    TK_WORD = 2'd1,
    TK_SYM  = 2'd2,
    TK_LIT  = 2'd3
  } token_kind_e;

  typedef struct packed {
    event_kind_e         ev;
    token_kind_e         kind;
    logic [CHAR_W-1:0]   ch;
    logic [LINE_W-1:0]   line;
    logic                trunc;
  } event_t;

  // All events caused by one input byte.
  typedef struct packed {
    logic [NSLOT-1:0]   vld;
    event_t [NSLOT-1:0] slot;
  } bundle_t;

  // Lexer state carried from byte to byte.
  typedef struct packed {
    lex_mode_e          mode;
    logic [LEN_W-1:0]   len;
    logic               ovf;
    logic [LINE_W-1:0]  line_count;
    logic [LINE_W-1:0]  token_line;
    logic               esc_pend;
    logic               prev_esc;
  } lex_state_t;

  // Token type reported for an open token of a given mode.
  function automatic token_kind_e mode_kind(lex_mode_e m);
    token_kind_e k;
    unique case (m)
      MODE_NUM:  k = TK_NUM;
      MODE_WORD: k = TK_WORD;
      default:   k = TK_LIT;
    endcase
    return k;
  endfunction

  function automatic event_t mk_evt(event_kind_e ev, token_kind_e kind,
                                    logic [CHAR_W-1:0] ch, logic [LINE_W-1:0] line,
                                    logic trunc);
    event_t e;
    e.ev    = ev;
    e.kind  = kind;
    e.ch    = ch;
    e.line  = line;
    e.trunc = trunc;
    return e;
  endfunction

endpackage

### hdl/stt_front.sv
// Front of the tokenizer: accepts bytes, holds the lexer state and the
// configuration registers, and turns each byte into a bundle of events.
// Depends on stt_pkg.
module stt_front #(
  parameter int unsigned NUMBER_LEN_MAX  = 29,
  parameter int unsigned WORD_LEN_MAX    = 49,
  parameter int unsigned LITERAL_LEN_MAX = 99,
  parameter int unsigned LINE_BITS       = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [7:0]              char_value_i,
  input  logic                    end_of_text_i,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [7:0]              cfg_data_i,
  output logic                    bnd_push_o,
  output stt_pkg::bundle_t        bnd_o,
  input  logic                    bnd_full_i
);
  import stt_pkg::*;

  localparam logic [LINE_W-1:0] LineLimit = (LINE_BITS >= LINE_W) ? {LINE_W{1'b1}} :
                                            LINE_W'((64'd1 << LINE_BITS) - 64'd1);

  typedef struct packed {
    lex_state_t st;
    logic       vld;
    event_t     evt;
  } app_t;

  lex_state_t        st_q, st_d;
  logic [CHAR_W-1:0] quote_q, escape_q;
  logic              accept;
  logic [NSLOT-1:0]  vld;
  event_t [NSLOT-1:0] slot;

  // Length cap of the open token.
  function automatic logic [LEN_W-1:0] mode_cap(lex_mode_e m);
    logic [LEN_W-1:0] cap;
    unique case (m)
      MODE_NUM:  cap = LEN_W'(NUMBER_LEN_MAX);
      MODE_WORD: cap = LEN_W'(WORD_LEN_MAX);
      default:   cap = LEN_W'(LITERAL_LEN_MAX);
    endcase
    return cap;
  endfunction

  // Append one character to the open token, or note the overflow.
  function automatic app_t do_append(lex_state_t s, logic [CHAR_W-1:0] ch);
    app_t r;
    r.st  = s;
    r.vld = 1'b0;
    r.evt = mk_evt(EV_CHAR, mode_kind(s.mode), ch, s.token_line, 1'b0);
    if (s.mode != MODE_IDLE) begin
      if (s.len < mode_cap(s.mode)) begin
        r.vld    = 1'b1;
        r.st.len = s.len + LEN_W'(1);
      end else begin
        r.st.ovf = 1'b1;
      end
    end
    return r;
  endfunction

  // End the open token, if there is one, and return to idle.
  function automatic app_t do_close(lex_state_t s);
    app_t r;
    r.st      = s;
    r.vld     = (s.mode != MODE_IDLE);
    r.evt     = mk_evt(EV_END, mode_kind(s.mode), '0, s.token_line, s.ovf);
    r.st.mode = MODE_IDLE;
    r.st.len  = '0;
    r.st.ovf  = 1'b0;
    return r;
  endfunction

  // Start a new token on the current line.
  function automatic app_t do_open(lex_state_t s, lex_mode_e m);
    app_t r;
    r.st            = s;
    r.st.mode       = m;
    r.st.len        = '0;
    r.st.ovf        = 1'b0;
    r.st.token_line = s.line_count;
    r.vld           = 1'b1;
    r.evt           = mk_evt(EV_START, mode_kind(m), '0, s.line_count, 1'b0);
    return r;
  endfunction

  function automatic logic is_operator(logic [CHAR_W-1:0] c);
    return (c == "=") || (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
           (c == "(") || (c == ")") || (c == "{") || (c == "}") || (c == ";") ||
           (c == ",");
  endfunction

  function automatic logic is_letter(logic [CHAR_W-1:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == "_");
  endfunction

  assign accept = push & ~bnd_full_i;
  assign full   = bnd_full_i;

  // Work through one byte the way the lexer sees it, filling event slots in order.
  always_comb begin
    lex_state_t        s;
    app_t              a;
    logic [CHAR_W-1:0] c;
    s    = st_q;
    a    = '0;
    c    = char_value_i;
    vld  = '0;
    slot = '0;

    // An escape held from the previous byte is kept unless a quote follows.
    if (s.esc_pend) begin
      s.esc_pend = 1'b0;
      if ((c != quote_q) && (s.mode == MODE_LIT)) begin
        a = do_append(s, escape_q);
        s = a.st;
        vld[SLOT_PRE_ESC]  = a.vld;
        slot[SLOT_PRE_ESC] = a.evt;
      end
    end

    // Classify the byte; newline first, then literal contents, then fixed classes.
    priority if (c == CH_NEWLINE) begin
      if (s.line_count < LineLimit) begin
        s.line_count = s.line_count + LINE_W'(1);
      end
    end else if (s.mode == MODE_LIT) begin
      if (c == quote_q) begin
        if (s.prev_esc) begin
          a = do_append(s, c);
          s = a.st;
          vld[SLOT_CHAR]  = a.vld;
          slot[SLOT_CHAR] = a.evt;
        end else begin
          a = do_close(s);
          s = a.st;
          vld[SLOT_CLOSE]  = a.vld;
          slot[SLOT_CLOSE] = a.evt;
        end
      end else if (c == escape_q) begin
        s.esc_pend = 1'b1;
      end else begin
        a = do_append(s, c);
        s = a.st;
        vld[SLOT_CHAR]  = a.vld;
        slot[SLOT_CHAR] = a.evt;
      end
    end else if ((c >= "0") && (c <= "9")) begin
      if (s.mode == MODE_IDLE) begin
        a = do_open(s, MODE_NUM);
        s = a.st;
        vld[SLOT_OPEN]  = a.vld;
        slot[SLOT_OPEN] = a.evt;
      end
      a = do_append(s, c);
      s = a.st;
      vld[SLOT_CHAR]  = a.vld;
      slot[SLOT_CHAR] = a.evt;
    end else if (c == CH_SPACE) begin
      a = do_close(s);
      s = a.st;
      vld[SLOT_CLOSE]  = a.vld;
      slot[SLOT_CLOSE] = a.evt;
    end else if (is_operator(c)) begin
      a = do_close(s);
      s = a.st;
      vld[SLOT_CLOSE]    = a.vld;
      slot[SLOT_CLOSE]   = a.evt;
      vld[SLOT_OPEN]     = 1'b1;
      slot[SLOT_OPEN]    = mk_evt(EV_START, TK_SYM, '0, s.line_count, 1'b0);
      vld[SLOT_CHAR]     = 1'b1;
      slot[SLOT_CHAR]    = mk_evt(EV_CHAR, TK_SYM, c, s.line_count, 1'b0);
      vld[SLOT_SYM_END]  = 1'b1;
      slot[SLOT_SYM_END] = mk_evt(EV_END, TK_SYM, '0, s.line_count, 1'b0);
    end else if (is_letter(c)) begin
      if (s.mode == MODE_NUM) begin
        a = do_close(s);
        s = a.st;
        vld[SLOT_CLOSE]  = a.vld;
        slot[SLOT_CLOSE] = a.evt;
      end
      if (s.mode == MODE_IDLE) begin
        a = do_open(s, MODE_WORD);
        s = a.st;
        vld[SLOT_OPEN]  = a.vld;
        slot[SLOT_OPEN] = a.evt;
      end
      a = do_append(s, c);
      s = a.st;
      vld[SLOT_CHAR]  = a.vld;
      slot[SLOT_CHAR] = a.evt;
    end else if (c == quote_q) begin
      if (s.prev_esc) begin
        a = do_append(s, c);
        s = a.st;
        vld[SLOT_CHAR]  = a.vld;
        slot[SLOT_CHAR] = a.evt;
      end else if (s.mode == MODE_IDLE) begin
        a = do_open(s, MODE_LIT);
        s = a.st;
        vld[SLOT_OPEN]  = a.vld;
        slot[SLOT_OPEN] = a.evt;
      end
    end else begin
      if (s.mode == MODE_NUM) begin
        a = do_close(s);
        s = a.st;
        vld[SLOT_CLOSE]  = a.vld;
        slot[SLOT_CLOSE] = a.evt;
      end else begin
        a = do_append(s, c);
        s = a.st;
        vld[SLOT_CHAR]  = a.vld;
        slot[SLOT_CHAR] = a.evt;
      end
    end

    s.prev_esc = (c == escape_q);

    // End of text flushes a held escape, closes the token and restarts the text.
    if (end_of_text_i) begin
      if (s.esc_pend) begin
        s.esc_pend = 1'b0;
        if (s.mode == MODE_LIT) begin
          a = do_append(s, escape_q);
          s = a.st;
          vld[SLOT_EOT_ESC]  = a.vld;
          slot[SLOT_EOT_ESC] = a.evt;
        end
      end
      a = do_close(s);
      s = a.st;
      vld[SLOT_EOT_END]  = a.vld;
      slot[SLOT_EOT_END] = a.evt;
      s.prev_esc   = 1'b0;
      s.line_count = '0;
    end

    st_d = s;
  end

  // A byte that causes no event leaves nothing in the queue.
  assign bnd_push_o = accept & (|vld);
  assign bnd_o.vld  = vld;
  assign bnd_o.slot = slot;

  // Lexer state advances on every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode       <= MODE_IDLE;
      st_q.len        <= '0;
      st_q.ovf        <= 1'b0;
      st_q.line_count <= '0;
      st_q.token_line <= '0;
      st_q.esc_pend   <= 1'b0;
      st_q.prev_esc   <= 1'b0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q  <= QUOTE_RESET;
      escape_q <= ESCAPE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_QUOTE:  quote_q  <= cfg_data_i;
        REG_ESCAPE: escape_q <= cfg_data_i;
        default:    quote_q  <= quote_q;
      endcase
    end
  end

endmodule

### hdl/stt_queue.sv
// Short queue of event bundles between the tokenizer front and back.
// Depends on stt_pkg.
module stt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  stt_pkg::bundle_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output stt_pkg::bundle_t data_o
);
  import stt_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  bundle_t         mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### hdl/stt_back.sv
// Back of the tokenizer: takes event bundles and hands out one event per
// transaction through an output register. Depends on stt_pkg.
module stt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             bnd_valid_i,
  input  stt_pkg::bundle_t bnd_i,
  output logic             bnd_pop_o,
  output logic             empty,
  input  logic             pop,
  output logic [1:0]       event_kind_o,
  output logic [1:0]       token_kind_o,
  output logic [7:0]       out_char_o,
  output logic [23:0]      line_number_o,
  output logic             truncated_o,
  output logic             last_of_run_o
);
  import stt_pkg::*;

  logic [NSLOT-1:0]   mask_q, mask_d, rest;
  event_t [NSLOT-1:0] slot_q;
  logic [SLOT_W-1:0]  sel;
  logic               out_valid_q, out_valid_d;
  event_t             out_q;
  logic               out_last_q;
  logic               adv, emit;

  // Lowest pending slot goes next.
  always_comb begin
    sel = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = SLOT_W'(i);
      end
    end
  end

  assign rest = mask_q & ~(NSLOT'(1) << sel);
  assign adv  = ~out_valid_q | pop;
  assign emit = adv & (|mask_q);

  always_comb begin
    mask_d      = mask_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      mask_d      = rest;
      out_valid_d = 1'b1;
    end else if (adv) begin
      out_valid_d = 1'b0;
    end
  end

  // Load the next bundle once the current one has no events left.
  assign bnd_pop_o = bnd_valid_i & (mask_d == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= bnd_pop_o ? bnd_i.vld : mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (bnd_pop_o) begin
      slot_q <= bnd_i.slot;
    end
    if (emit) begin
      out_q      <= slot_q[sel];
      out_last_q <= (rest == '0);
    end
  end

  assign empty         = ~out_valid_q;
  assign event_kind_o  = out_q.ev;
  assign token_kind_o  = out_q.kind;
  assign out_char_o    = out_q.ch;
  assign line_number_o = out_q.line;
  assign truncated_o   = out_q.trunc;
  assign last_of_run_o = out_last_q;

endmodule

### hdl/source_text_tokenizer.sv
// Streaming tokenizer: one source byte in per transaction, token start,
// character and end events out per transaction. The front accepts a byte in
// every cycle in which full is low and works it into a bundle of up to four
// events in that same cycle; a two-entry bundle queue feeds the back, which
// hands out one event per clock through its output register unless a held
// event waits for pop. A byte thus yields zero to four output events;
// sustained throughput is set by the single event port at one event per
// clock while pop stays high. Bytes that cause no event (newlines, dropped
// characters) never reach the queue. The user must write the configuration
// registers, quote (index 0) and escape (index 1), only while the block is
// idle; the block itself does not enforce this. There is no clearing pass
// after reset. Depends on stt_pkg, stt_front, stt_queue and stt_back.
module source_text_tokenizer #(
  parameter int unsigned NUMBER_LEN_MAX  = 29,
  parameter int unsigned WORD_LEN_MAX    = 49,
  parameter int unsigned LITERAL_LEN_MAX = 99,
  parameter int unsigned LINE_BITS       = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_value_i,
  input  logic        end_of_text_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  event_kind_o,
  output logic [1:0]  token_kind_o,
  output logic [7:0]  out_char_o,
  output logic [23:0] line_number_o,
  output logic        truncated_o,
  output logic        last_of_run_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  import stt_pkg::*;

  logic    fq_push, fq_full, qb_valid, qb_pop;
  bundle_t fq_data, qb_data;

  // Byte classification and lexer state.
  stt_front #(
    .NUMBER_LEN_MAX  (NUMBER_LEN_MAX),
    .WORD_LEN_MAX    (WORD_LEN_MAX),
    .LITERAL_LEN_MAX (LITERAL_LEN_MAX),
    .LINE_BITS       (LINE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .char_value_i  (char_value_i),
    .end_of_text_i (end_of_text_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .bnd_push_o    (fq_push),
    .bnd_o         (fq_data),
    .bnd_full_i    (fq_full)
  );

  // Bundle queue.
  stt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_data),
    .full_o  (fq_full),
    .pop_i   (qb_pop),
    .valid_o (qb_valid),
    .data_o  (qb_data)
  );

  // Event serializer and output register.
  stt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bnd_valid_i   (qb_valid),
    .bnd_i         (qb_data),
    .bnd_pop_o     (qb_pop),
    .empty         (empty),
    .pop           (pop),
    .event_kind_o  (event_kind_o),
    .token_kind_o  (token_kind_o),
    .out_char_o    (out_char_o),
    .line_number_o (line_number_o),
    .truncated_o   (truncated_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
